[hdl/bad_node_avoiding_selector_unit_macros.svh]
// ----------------------------------------------------------------------------
// Bad node avoiding selector assertion macros
// Concurrent assertion helpers used by the selector top level.
// ----------------------------------------------------------------------------
`ifndef BAD_NODE_AVOIDING_SELECTOR_UNIT_MACROS_SVH
`define BAD_NODE_AVOIDING_SELECTOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define BNAS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define BNAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BNAS_ASSERT_IMP(label, clk, rst, ante, cons)
`define BNAS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[hdl/bnas_pkg.sv]
// ----------------------------------------------------------------------------
// Bad node avoiding selector package
// Sizes, codes and the sequencer state type shared by the selector files.
// ----------------------------------------------------------------------------
package bnas_pkg;

   localparam int TABLE_DEPTH  = 16;
   localparam int NODE_ID_BITS = 16;
   localparam int IDX_W        = $clog2(TABLE_DEPTH);

   localparam int MODE_W   = 2;
   localparam int NODE_W   = 16;
   localparam int TIME_W   = 32;
   localparam int CLASS_W  = 2;
   localparam int STATUS_W = 2;
   localparam int ADDR_W   = 3;
   localparam int DATA_W   = 32;

   localparam logic [NODE_W-1:0] NODE_MASK =
      (NODE_ID_BITS >= NODE_W) ? {NODE_W{1'b1}} : NODE_W'((1 << NODE_ID_BITS) - 1);

   localparam logic [MODE_W-1:0] MODE_CAND = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SLOW = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FAIL = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

   localparam logic KIND_SELECT = 1'b0;
   localparam logic KIND_MARK   = 1'b1;

   localparam logic [CLASS_W-1:0] CLASS_GOOD = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_SLOW = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_FAIL = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_STORED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

   localparam logic REG_SLOW_TIMEOUT = 1'b0;
   localparam logic REG_FAIL_TIMEOUT = 1'b1;

   localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd60000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EVAL,
      ST_APPLY,
      ST_EMIT
   } bnas_state_type;

endpackage

[hdl/bnas_if.sv]
// ----------------------------------------------------------------------------
// Bad node avoiding selector channels
// Valid/ready interfaces for the request and response transactions.
// ----------------------------------------------------------------------------
interface bnas_req_if;
   import bnas_pkg::*;

   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [NODE_W-1:0] node_id;
   logic              last;
   logic [TIME_W-1:0] now_ms;

   modport source (output valid, output mode, output node_id, output last,
                   output now_ms, input ready);
   modport sink   (input valid, input mode, input node_id, input last,
                   input now_ms, output ready);
endinterface

interface bnas_rsp_if;
   import bnas_pkg::*;

   logic                valid;
   logic                ready;
   logic                kind;
   logic [NODE_W-1:0]   chosen_node;
   logic                found;
   logic [CLASS_W-1:0]  choice_class;
   logic [STATUS_W-1:0] mark_status;

   modport source (output valid, output kind, output chosen_node, output found,
                   output choice_class, output mark_status, input ready);
   modport sink   (input valid, input kind, input chosen_node, input found,
                   input choice_class, input mark_status, output ready);
endinterface

[hdl/bad_node_avoiding_selector_unit.sv]
// ----------------------------------------------------------------------------
// Bad node avoiding selector
// Keeps a table of slow and failed nodes and picks a node from candidate lists.
// ----------------------------------------------------------------------------
// Requests arrive on req_if. A mark transaction (mode slow or failed) stores or
// refreshes a table entry unless it is rejected or the table is full, and always
// returns one acknowledgement on rsp_if. A candidate transaction adds one node
// to the current selection list; only the candidate flagged last returns the
// selection answer. Mode three is dropped in the accepting cycle with no response.
// Each transaction walks the table one entry per cycle through a single node
// comparator, stopping at the first match, then forms the entry age in the
// EVAL state and applies the update in the APPLY state. req_if.ready is low
// from acceptance until the sequencer returns to idle. The response sits in
// an output register; a stalled receiver holds the block only when a second
// response is ready to load.
// Reset clears the table, the list state and the response valid flag, and sets
// both timeouts to 60000 ms. The timeouts are written over the csr_ port.
// ----------------------------------------------------------------------------
`include "bad_node_avoiding_selector_unit_macros.svh"

module bad_node_avoiding_selector_unit (
   input  logic                          clock,
   input  logic                          reset,
   bnas_req_if.sink                      req_if,
   bnas_rsp_if.source                    rsp_if,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [bnas_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [bnas_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [bnas_pkg::DATA_W-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import bnas_pkg::*;

   bnas_state_type state_ff, state_in;

   logic [MODE_W-1:0] mode_ff;
   logic [NODE_W-1:0] node_ff;
   logic              last_ff;
   logic [TIME_W-1:0] now_ff;

   logic [TIME_W-1:0] slow_to_ff;
   logic [TIME_W-1:0] fail_to_ff;

   logic              ent_valid_ff  [TABLE_DEPTH];
   logic [NODE_W-1:0] ent_node_ff   [TABLE_DEPTH];
   logic              ent_failed_ff [TABLE_DEPTH];
   logic [TIME_W-1:0] ent_start_ff  [TABLE_DEPTH];

   logic [TIME_W-1:0] list_time_ff;
   logic              list_active_ff;
   logic              list_decided_ff;
   logic [NODE_W-1:0] decided_node_ff;
   logic              slow_best_valid_ff;
   logic [NODE_W-1:0] slow_best_node_ff;
   logic [TIME_W-1:0] slow_best_start_ff;
   logic              fail_best_valid_ff;
   logic [NODE_W-1:0] fail_best_node_ff;
   logic [TIME_W-1:0] fail_best_start_ff;

   logic [IDX_W-1:0]    idx_ff;
   logic                hit_ff;
   logic [IDX_W-1:0]    hit_idx_ff;
   logic                free_ff;
   logic [IDX_W-1:0]    free_idx_ff;
   logic [TIME_W-1:0]   age_ff;
   logic [TIME_W-1:0]   lim_ff;
   logic [TIME_W-1:0]   best_age_ff;
   logic [STATUS_W-1:0] status_ff;

   logic                rsp_valid_ff;
   logic                rsp_kind_ff;
   logic [NODE_W-1:0]   rsp_node_ff;
   logic                rsp_found_ff;
   logic [CLASS_W-1:0]  rsp_class_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   logic              req_accept;
   logic              scan_match;
   logic              scan_done;
   logic              emit_go;
   logic              csr_write;
   logic [TIME_W-1:0] eval_time;
   logic              expired;
   logic              older;
   logic              hit_failed;
   logic [IDX_W-1:0]  wr_idx;

   assign req_accept = req_if.valid && req_if.ready;
   assign scan_match = ent_valid_ff[idx_ff] && (ent_node_ff[idx_ff] == node_ff);
   assign scan_done  = scan_match || (idx_ff == IDX_W'(TABLE_DEPTH - 1));
   assign emit_go    = !rsp_valid_ff || rsp_if.ready;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign eval_time  = (mode_ff == MODE_CAND) ? list_time_ff : now_ff;
   assign expired    = age_ff > lim_ff;
   assign older      = age_ff > best_age_ff;
   assign hit_failed = ent_failed_ff[hit_idx_ff];
   assign wr_idx     = hit_ff ? hit_idx_ff : free_idx_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_if.mode != MODE_NONE)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if ((mode_ff == MODE_CAND) && !last_ff) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_if.ready = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_if.ready = 1'b1;
         ST_SCAN:  req_if.ready = 1'b0;
         ST_EVAL:  req_if.ready = 1'b0;
         ST_APPLY: req_if.ready = 1'b0;
         ST_EMIT:  req_if.ready = 1'b0;
         default:  req_if.ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slow_to_ff <= TIMEOUT_RESET;
         fail_to_ff <= TIMEOUT_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_SLOW_TIMEOUT: slow_to_ff <= csr_pwdata;
            REG_FAIL_TIMEOUT: fail_to_ff <= csr_pwdata;
            default:          slow_to_ff <= slow_to_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_SLOW_TIMEOUT: csr_prdata = slow_to_ff;
         REG_FAIL_TIMEOUT: csr_prdata = fail_to_ff;
         default:          csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               mode_ff     <= req_if.mode;
               node_ff     <= req_if.node_id & NODE_MASK;
               last_ff     <= req_if.last;
               now_ff      <= req_if.now_ms;
               idx_ff      <= '0;
               hit_ff      <= 1'b0;
               hit_idx_ff  <= '0;
               free_ff     <= 1'b0;
               free_idx_ff <= '0;
            end
         end
         ST_SCAN: begin
            if (scan_match) begin
               hit_ff     <= 1'b1;
               hit_idx_ff <= idx_ff;
            end
            if (!ent_valid_ff[idx_ff] && !free_ff) begin
               free_ff     <= 1'b1;
               free_idx_ff <= idx_ff;
            end
            if (!scan_done) begin
               idx_ff <= idx_ff + IDX_W'(1);
            end
         end
         ST_EVAL: begin
            age_ff      <= eval_time - ent_start_ff[hit_idx_ff];
            lim_ff      <= ent_failed_ff[hit_idx_ff] ? fail_to_ff : slow_to_ff;
            best_age_ff <= list_time_ff - (ent_failed_ff[hit_idx_ff] ?
                                           fail_best_start_ff : slow_best_start_ff);
         end
         ST_APPLY: begin
            if (hit_ff && !expired && hit_failed && (mode_ff == MODE_SLOW)) begin
               status_ff <= STATUS_REJECT;
            end else if (!hit_ff && !free_ff) begin
               status_ff <= STATUS_FULL;
            end else begin
               status_ff <= STATUS_STORED;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_APPLY) && (mode_ff != MODE_CAND) &&
          !(hit_ff && !expired && hit_failed && (mode_ff == MODE_SLOW)) &&
          (hit_ff || free_ff)) begin
         ent_node_ff[wr_idx]   <= node_ff;
         ent_failed_ff[wr_idx] <= (mode_ff == MODE_FAIL);
         ent_start_ff[wr_idx]  <= now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            ent_valid_ff[i] <= 1'b0;
         end
      end else if (state_ff == ST_APPLY) begin
         if (mode_ff == MODE_CAND) begin
            if (!list_decided_ff && hit_ff && expired) begin
               ent_valid_ff[hit_idx_ff] <= 1'b0;
            end
         end else if (!(hit_ff && !expired && hit_failed && (mode_ff == MODE_SLOW)) &&
                      (hit_ff || free_ff)) begin
            ent_valid_ff[wr_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         list_time_ff       <= '0;
         list_active_ff     <= 1'b0;
         list_decided_ff    <= 1'b0;
         decided_node_ff    <= '0;
         slow_best_valid_ff <= 1'b0;
         slow_best_node_ff  <= '0;
         slow_best_start_ff <= '0;
         fail_best_valid_ff <= 1'b0;
         fail_best_node_ff  <= '0;
         fail_best_start_ff <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_accept && (req_if.mode == MODE_CAND) && !list_active_ff) begin
                  list_active_ff <= 1'b1;
                  list_time_ff   <= req_if.now_ms;
               end
            end
            ST_APPLY: begin
               if ((mode_ff == MODE_CAND) && !list_decided_ff) begin
                  if (!hit_ff || expired) begin
                     list_decided_ff <= 1'b1;
                     decided_node_ff <= node_ff;
                  end else if (!hit_failed) begin
                     if (!slow_best_valid_ff || older) begin
                        slow_best_valid_ff <= 1'b1;
                        slow_best_node_ff  <= node_ff;
                        slow_best_start_ff <= ent_start_ff[hit_idx_ff];
                     end
                  end else begin
                     if (!fail_best_valid_ff || older) begin
                        fail_best_valid_ff <= 1'b1;
                        fail_best_node_ff  <= node_ff;
                        fail_best_start_ff <= ent_start_ff[hit_idx_ff];
                     end
                  end
               end
            end
            ST_EMIT: begin
               if (emit_go && (mode_ff == MODE_CAND)) begin
                  list_time_ff       <= '0;
                  list_active_ff     <= 1'b0;
                  list_decided_ff    <= 1'b0;
                  decided_node_ff    <= '0;
                  slow_best_valid_ff <= 1'b0;
                  slow_best_node_ff  <= '0;
                  slow_best_start_ff <= '0;
                  fail_best_valid_ff <= 1'b0;
                  fail_best_node_ff  <= '0;
                  fail_best_start_ff <= '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_EMIT) && emit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_EMIT) && emit_go) begin
         if (mode_ff == MODE_CAND) begin
            rsp_kind_ff   <= KIND_SELECT;
            rsp_status_ff <= STATUS_STORED;
            if (list_decided_ff) begin
               rsp_node_ff  <= decided_node_ff;
               rsp_found_ff <= 1'b1;
               rsp_class_ff <= CLASS_GOOD;
            end else if (slow_best_valid_ff) begin
               rsp_node_ff  <= slow_best_node_ff;
               rsp_found_ff <= 1'b1;
               rsp_class_ff <= CLASS_SLOW;
            end else if (fail_best_valid_ff) begin
               rsp_node_ff  <= fail_best_node_ff;
               rsp_found_ff <= 1'b1;
               rsp_class_ff <= CLASS_FAIL;
            end else begin
               rsp_node_ff  <= '0;
               rsp_found_ff <= 1'b0;
               rsp_class_ff <= CLASS_GOOD;
            end
         end else begin
            rsp_kind_ff   <= KIND_MARK;
            rsp_node_ff   <= node_ff;
            rsp_found_ff  <= 1'b0;
            rsp_class_ff  <= CLASS_GOOD;
            rsp_status_ff <= status_ff;
         end
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.kind         = rsp_kind_ff;
   assign rsp_if.chosen_node  = rsp_node_ff;
   assign rsp_if.found        = rsp_found_ff;
   assign rsp_if.choice_class = rsp_class_ff;
   assign rsp_if.mark_status  = rsp_status_ff;

   `BNAS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_accept && (req_if.mode != MODE_NONE), !req_if.ready)
   `BNAS_ASSERT_IMP(a_decided_in_list, clock, reset, list_decided_ff, list_active_ff)
   `BNAS_ASSERT_IMP(a_empty_answer_zero, clock, reset, rsp_valid_ff && (rsp_kind_ff == KIND_SELECT) && !rsp_found_ff, rsp_node_ff == '0)

endmodule
